/* rtl/core/jscg_pkg.sv */
// Shared constants, result type and saturating Q48.16 helpers for the solver.
`default_nettype none
package jscg_pkg;

  // Input actions.
  localparam logic [1:0] ACT_LOAD_MAT = 2'd0;
  localparam logic [1:0] ACT_LOAD_RHS = 2'd1;
  localparam logic [1:0] ACT_START    = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_CONVERGED = 2'd0;
  localparam logic [1:0] STATUS_LIMIT     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DEN  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_MAXIT = 2'd1;
  localparam logic [1:0] REG_TOL   = 2'd2;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  // Status and result returned by an arithmetic unit.
  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } unit_result_t;

  // Saturating signed 64-bit add.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? Q_MIN : Q_MAX;
    end
    return s;
  endfunction

  // Saturating signed negate.
  function automatic logic [63:0] sat_neg(input logic [63:0] a);
    return (a == Q_MIN) ? Q_MAX : (64'd0 - a);
  endfunction

  // Absolute value as an unsigned magnitude.
  function automatic logic [63:0] magnitude(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // Signed result from a magnitude, saturated on overflow.
  function automatic logic [63:0] from_mag(input logic [63:0] m, input logic neg,
                                           input logic over);
    if (over || m[63]) begin
      return neg ? Q_MIN : Q_MAX;
    end
    return neg ? (64'd0 - m) : m;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/jscg_req_if.sv */
// Input item channel: action, indexes and entry value.
`default_nettype none
interface jscg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  row;
  logic [5:0]  col;
  logic [31:0] value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink (input valid, action, row, col, value, output ready);
endinterface
`default_nettype wire

/* rtl/core/jscg_rsp_if.sv */
// Result channel: one solution element per beat.
`default_nettype none
interface jscg_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  index;
  logic [31:0] solution;
  logic [15:0] iterations_done;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, index, solution, iterations_done, status, last,
                  input ready);
  modport sink (input valid, index, solution, iterations_done, status, last,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/jscg_cfg_if.sv */
// Configuration write channel: register index and write data.
`default_nettype none
interface jscg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/jacobi_scaled_cg_solver_unit.sv */
// Jacobi-scaled conjugate gradient solver: sequencer, stores and arithmetic units.
//
// Usage: load beats on req (action 0 matrix entry at row/col, action 1 right-hand
// side entry at row) are taken while idle. An action 2 beat starts a solve; req is
// not ready again until the last result beat has been taken. Configuration writes
// on cfg are taken in every cycle and belong only to idle periods.
// A solve first takes the square root of each diagonal entry, then scales the
// right-hand side with one division per row and the matrix with two per entry.
// Every multiply-accumulate uses the shared multiplier (four partial products);
// one iteration runs two matrix-vector products and four dot products, plus two
// divisions for alpha and beta. The result stream then takes one division per
// element (zeros without division when a zero denominator ends the solve before
// the first iteration completes); the next element starts once the beat is taken.
// Results hold on rsp while the receiver stalls; nothing is dropped.
// Reset restores the register defaults (size 64, limit 1000, tolerance 0) and
// idles the sequencer; loaded stores are not cleared and hold until written.
`default_nettype none
module jacobi_scaled_cg_solver_unit import jscg_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  jscg_req_if.sink  req,
  jscg_rsp_if.source rsp,
  jscg_cfg_if.sink  cfg
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [27:0] {
    ST_IDLE     = 28'h0000001,
    ST_DG_RD    = 28'h0000002,
    ST_DG_CK    = 28'h0000004,
    ST_DG_WT    = 28'h0000008,
    ST_SC_ROW   = 28'h0000010,
    ST_SC_RI    = 28'h0000020,
    ST_SC_RWT   = 28'h0000040,
    ST_SC_RD    = 28'h0000080,
    ST_SC_D1    = 28'h0000100,
    ST_SC_W1    = 28'h0000200,
    ST_SC_D2    = 28'h0000400,
    ST_SC_W2    = 28'h0000800,
    ST_MAC_RD   = 28'h0001000,
    ST_MAC_MUL  = 28'h0002000,
    ST_MAC_WT   = 28'h0004000,
    ST_MAC_END  = 28'h0008000,
    ST_TEST     = 28'h0010000,
    ST_QDIV     = 28'h0020000,
    ST_QDIV_WT  = 28'h0040000,
    ST_UPD_RD   = 28'h0080000,
    ST_UPD_M1   = 28'h0100000,
    ST_UPD_W1   = 28'h0200000,
    ST_UPD_M2   = 28'h0400000,
    ST_UPD_W2   = 28'h0800000,
    ST_OUT_RD   = 28'h1000000,
    ST_OUT_DV   = 28'h2000000,
    ST_OUT_WT   = 28'h4000000,
    ST_OUT_EMIT = 28'h8000000
  } state_t;

  // Which vector job of the iteration is running.
  typedef enum logic [8:0] {
    PH_RS0  = 9'h001,
    PH_NUM  = 9'h002,
    PH_AP   = 9'h004,
    PH_DEN  = 9'h008,
    PH_UPD  = 9'h010,
    PH_RS1  = 9'h020,
    PH_ARP  = 9'h040,
    PH_BNUM = 9'h080,
    PH_PUPD = 9'h100
  } phase_t;

  state_t      state;
  phase_t      phase;

  // Configuration registers.
  logic [6:0]  size_reg;
  logic [15:0] maxit_reg;
  logic [31:0] tol_reg;

  // Sequencer registers.
  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] j_inc;
  logic [31:0]   ri;
  logic [31:0]   rj;
  logic [63:0]   tval;
  logic [63:0]   acc;
  logic [63:0]   rs;
  logic [63:0]   num;
  logic [63:0]   den;
  logic [63:0]   coef;
  logic [63:0]   vx;
  logic [63:0]   vr;
  logic [63:0]   vq;
  logic [31:0]   sol;
  logic [15:0]   iter;
  logic [1:0]    status;

  // Memory ports.
  logic          a_we;
  logic [AW-1:0] a_waddr;
  logic [AW-1:0] a_raddr;
  logic [31:0]   a_q;
  logic          rhs_we;
  logic [31:0]   rhs_q;
  logic          root_we;
  logic [IW-1:0] root_raddr;
  logic [31:0]   root_q;
  logic          s_we;
  logic [AW-1:0] s_addr;
  logic [63:0]   s_q;
  logic [IW-1:0] vaddr;
  logic          x_we;
  logic          r_we;
  logic          p_we;
  logic          q_we;
  logic [63:0]   x_wdata;
  logic [63:0]   r_wdata;
  logic [63:0]   p_wdata;
  logic [63:0]   x_q;
  logic [63:0]   r_q;
  logic [63:0]   p_q;
  logic [63:0]   q_q;

  // Arithmetic unit ports.
  logic          mul_start;
  logic [63:0]   mul_a;
  logic [63:0]   mul_b;
  unit_result_t  mul_res;
  logic          div_start;
  logic [63:0]   div_n;
  logic [63:0]   div_d;
  unit_result_t  div_res;
  logic          sqrt_start;
  unit_result_t  sqrt_res;

  logic          mac_state;
  logic          is_matvec;
  logic          zero_out;
  logic          load_beat;
  logic [63:0]   mac_a;
  logic [63:0]   mac_b;
  logic [63:0]   div_q;

  assign i_inc     = i + CW'(1);
  assign j_inc     = j + CW'(1);
  assign load_beat = req.valid && req.ready;
  assign mac_state = (state == ST_MAC_RD) || (state == ST_MAC_MUL) || (state == ST_MAC_WT);
  assign is_matvec = (phase == PH_AP) || (phase == PH_ARP);
  assign zero_out  = (status == STATUS_ZERO_DEN) && (iter == 16'd0);
  assign div_q     = div_res.value;

  // Store addressing and write enables.
  always_comb begin
    a_we    = load_beat && (req.action == ACT_LOAD_MAT) &&
              (int'(req.row) < MAX_DIM) && (int'(req.col) < MAX_DIM);
    a_waddr = AW'(int'(req.row) * MAX_DIM + int'(req.col));
    a_raddr = AW'(int'(i[IW-1:0]) * MAX_DIM +
                  int'((state == ST_DG_RD) ? i[IW-1:0] : j[IW-1:0]));
    rhs_we  = load_beat && (req.action == ACT_LOAD_RHS) && (int'(req.row) < MAX_DIM);
    root_we = (state == ST_DG_WT) && sqrt_res.done;
    root_raddr = (state == ST_SC_RD) ? j[IW-1:0] : i[IW-1:0];
    s_we    = (state == ST_SC_W2) && div_res.done;
    s_addr  = AW'(int'(i[IW-1:0]) * MAX_DIM + int'(j[IW-1:0]));
    vaddr   = mac_state ? j[IW-1:0] : i[IW-1:0];
    x_we    = ((state == ST_SC_RWT) && div_res.done) ||
              ((state == ST_UPD_W1) && mul_res.done && (phase == PH_UPD));
    r_we    = ((state == ST_SC_RWT) && div_res.done) ||
              ((state == ST_UPD_W2) && mul_res.done);
    p_we    = ((state == ST_SC_RWT) && div_res.done) ||
              ((state == ST_UPD_W1) && mul_res.done && (phase == PH_PUPD));
    q_we    = (state == ST_MAC_END) && is_matvec;
    x_wdata = (state == ST_SC_RWT) ? 64'd0 : sat_add(vx, mul_res.value);
    r_wdata = (state == ST_SC_RWT) ? div_q : sat_add(vr, sat_neg(mul_res.value));
    p_wdata = (state == ST_SC_RWT) ? div_q : sat_add(vr, sat_neg(mul_res.value));
  end

  // Multiply-accumulate operands for each vector job.
  always_comb begin
    unique case (phase)
      PH_RS0, PH_RS1: begin
        mac_a = r_q;
        mac_b = r_q;
      end
      PH_NUM: begin
        mac_a = p_q;
        mac_b = r_q;
      end
      PH_AP: begin
        mac_a = s_q;
        mac_b = p_q;
      end
      PH_DEN: begin
        mac_a = p_q;
        mac_b = q_q;
      end
      PH_ARP: begin
        mac_a = s_q;
        mac_b = r_q;
      end
      PH_BNUM: begin
        mac_a = q_q;
        mac_b = p_q;
      end
      default: begin
        mac_a = coef;
        mac_b = p_q;
      end
    endcase
  end

  // Arithmetic unit operand selection.
  always_comb begin
    mul_start  = (state == ST_MAC_MUL) || (state == ST_UPD_M1) || (state == ST_UPD_M2);
    mul_a      = (state == ST_MAC_MUL) ? mac_a : coef;
    mul_b      = (state == ST_MAC_MUL) ? mac_b : ((state == ST_UPD_M2) ? vq : p_q);
    sqrt_start = (state == ST_DG_CK) && !a_q[31] && (a_q != 32'd0);
    div_start  = (state == ST_SC_RI) || (state == ST_SC_D1) || (state == ST_SC_D2) ||
                 (state == ST_QDIV) || ((state == ST_OUT_DV) && !zero_out);
    priority case (1'b1)
      (state == ST_SC_RI): begin
        div_n = {{32{rhs_q[31]}}, rhs_q};
        div_d = {32'd0, root_q};
      end
      (state == ST_SC_D1): begin
        div_n = {{32{a_q[31]}}, a_q};
        div_d = {32'd0, ri};
      end
      (state == ST_SC_D2): begin
        div_n = tval;
        div_d = {32'd0, rj};
      end
      (state == ST_QDIV): begin
        div_n = num;
        div_d = den;
      end
      default: begin
        div_n = x_q;
        div_d = {32'd0, root_q};
      end
    endcase
  end

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg  <= 7'd64;
      maxit_reg <= 16'd1000;
      tol_reg   <= 32'd0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_SIZE:  size_reg  <= cfg.data[6:0];
        REG_MAXIT: maxit_reg <= cfg.data[15:0];
        REG_TOL:   tol_reg   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Solve sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      phase  <= PH_RS0;
      i      <= '0;
      j      <= '0;
      n      <= CW'(1);
      iter   <= '0;
      rs     <= '0;
      status <= STATUS_CONVERGED;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (load_beat && req.action == ACT_START) begin
            if (size_reg == 7'd0) begin
              n <= CW'(1);
            end else if (int'(size_reg) > MAX_DIM) begin
              n <= CW'(MAX_DIM);
            end else begin
              n <= CW'(size_reg);
            end
            iter  <= '0;
            i     <= '0;
            state <= ST_DG_RD;
          end
        end

        // Diagonal square roots.
        ST_DG_RD: state <= ST_DG_CK;
        ST_DG_CK: begin
          if (a_q[31] || a_q == 32'd0) begin
            status <= STATUS_ZERO_DEN;
            i      <= '0;
            state  <= ST_OUT_RD;
          end else begin
            state <= ST_DG_WT;
          end
        end
        ST_DG_WT: begin
          if (sqrt_res.done) begin
            if (i_inc == n) begin
              i     <= '0;
              state <= ST_SC_ROW;
            end else begin
              i     <= i_inc;
              state <= ST_DG_RD;
            end
          end
        end

        // Symmetric scaling of the matrix and right-hand side.
        ST_SC_ROW: state <= ST_SC_RI;
        ST_SC_RI: begin
          ri    <= root_q;
          state <= ST_SC_RWT;
        end
        ST_SC_RWT: begin
          if (div_res.done) begin
            j     <= '0;
            state <= ST_SC_RD;
          end
        end
        ST_SC_RD: state <= ST_SC_D1;
        ST_SC_D1: begin
          rj    <= root_q;
          state <= ST_SC_W1;
        end
        ST_SC_W1: begin
          if (div_res.done) begin
            tval  <= div_q;
            state <= ST_SC_D2;
          end
        end
        ST_SC_D2: state <= ST_SC_W2;
        ST_SC_W2: begin
          if (div_res.done) begin
            if (j_inc != n) begin
              j     <= j_inc;
              state <= ST_SC_RD;
            end else if (i_inc != n) begin
              i     <= i_inc;
              state <= ST_SC_ROW;
            end else begin
              phase <= PH_RS0;
              i     <= '0;
              j     <= '0;
              acc   <= '0;
              state <= ST_MAC_RD;
            end
          end
        end

        // Shared multiply-accumulate loop for dot and matrix-vector products.
        ST_MAC_RD:  state <= ST_MAC_MUL;
        ST_MAC_MUL: state <= ST_MAC_WT;
        ST_MAC_WT: begin
          if (mul_res.done) begin
            acc <= sat_add(acc, mul_res.value);
            if (j_inc == n) begin
              state <= ST_MAC_END;
            end else begin
              j     <= j_inc;
              state <= ST_MAC_RD;
            end
          end
        end
        ST_MAC_END: begin
          j   <= '0;
          acc <= '0;
          unique case (phase)
            PH_AP, PH_ARP: begin
              state <= ST_MAC_RD;
              if (i_inc == n) begin
                i     <= '0;
                phase <= (phase == PH_AP) ? PH_DEN : PH_BNUM;
              end else begin
                i <= i_inc;
              end
            end
            PH_RS0: begin
              rs    <= acc;
              state <= ST_TEST;
            end
            PH_NUM: begin
              num   <= acc;
              i     <= '0;
              phase <= PH_AP;
              state <= ST_MAC_RD;
            end
            PH_DEN: begin
              den <= acc;
              if (acc == 64'd0) begin
                status <= STATUS_ZERO_DEN;
                i      <= '0;
                state  <= ST_OUT_RD;
              end else begin
                state <= ST_QDIV;
              end
            end
            PH_RS1: begin
              rs   <= acc;
              iter <= iter + 16'd1;
              if (acc <= {32'd0, tol_reg}) begin
                status <= STATUS_CONVERGED;
                i      <= '0;
                state  <= ST_OUT_RD;
              end else begin
                i     <= '0;
                phase <= PH_ARP;
                state <= ST_MAC_RD;
              end
            end
            PH_BNUM: begin
              num   <= acc;
              state <= ST_QDIV;
            end
            default: state <= ST_IDLE;
          endcase
        end

        // Stop tests ahead of each iteration.
        ST_TEST: begin
          i <= '0;
          if (rs <= {32'd0, tol_reg}) begin
            status <= STATUS_CONVERGED;
            state  <= ST_OUT_RD;
          end else if (iter >= maxit_reg) begin
            status <= STATUS_LIMIT;
            state  <= ST_OUT_RD;
          end else begin
            j     <= '0;
            acc   <= '0;
            phase <= PH_NUM;
            state <= ST_MAC_RD;
          end
        end

        // Alpha or beta quotient.
        ST_QDIV: state <= ST_QDIV_WT;
        ST_QDIV_WT: begin
          if (div_res.done) begin
            coef  <= div_q;
            i     <= '0;
            phase <= (phase == PH_DEN) ? PH_UPD : PH_PUPD;
            state <= ST_UPD_RD;
          end
        end

        // Element-wise vector updates.
        ST_UPD_RD: state <= ST_UPD_M1;
        ST_UPD_M1: begin
          vx    <= x_q;
          vr    <= r_q;
          vq    <= q_q;
          state <= ST_UPD_W1;
        end
        ST_UPD_W1, ST_UPD_W2: begin
          if (mul_res.done) begin
            if (state == ST_UPD_W1 && phase == PH_UPD) begin
              state <= ST_UPD_M2;
            end else if (i_inc != n) begin
              i     <= i_inc;
              state <= ST_UPD_RD;
            end else if (phase == PH_UPD) begin
              i     <= '0;
              j     <= '0;
              acc   <= '0;
              phase <= PH_RS1;
              state <= ST_MAC_RD;
            end else begin
              state <= ST_TEST;
            end
          end
        end
        ST_UPD_M2: state <= ST_UPD_W2;

        // Unscale and stream the solution.
        ST_OUT_RD: state <= ST_OUT_DV;
        ST_OUT_DV: begin
          if (zero_out) begin
            sol   <= 32'd0;
            state <= ST_OUT_EMIT;
          end else begin
            state <= ST_OUT_WT;
          end
        end
        ST_OUT_WT: begin
          if (div_res.done) begin
            if (!div_q[63] && div_q[62:31] != 32'd0) begin
              sol <= 32'h7FFF_FFFF;
            end else if (div_q[63] && div_q[62:31] != 32'hFFFF_FFFF) begin
              sol <= 32'h8000_0000;
            end else begin
              sol <= div_q[31:0];
            end
            state <= ST_OUT_EMIT;
          end
        end
        ST_OUT_EMIT: begin
          if (rsp.ready) begin
            if (i_inc == n) begin
              state <= ST_IDLE;
            end else begin
              i     <= i_inc;
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Handshake outputs.
  assign req.ready           = (state == ST_IDLE);
  assign rsp.valid           = (state == ST_OUT_EMIT);
  assign rsp.index           = 6'(i);
  assign rsp.solution        = sol;
  assign rsp.iterations_done = iter;
  assign rsp.status          = status;
  assign rsp.last            = (i_inc == n);

  // Stores.
  jscg_ram #(.WIDTH(32), .DEPTH(MAX_DIM * MAX_DIM)) u_mat_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(req.value),
    .raddr(a_raddr), .rdata(a_q)
  );

  jscg_ram #(.WIDTH(64), .DEPTH(MAX_DIM * MAX_DIM)) u_scaled_ram (
    .clk(clk), .we(s_we), .waddr(s_addr), .wdata(div_q),
    .raddr(s_addr), .rdata(s_q)
  );

  jscg_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_rhs_ram (
    .clk(clk), .we(rhs_we), .waddr(IW'(req.row)), .wdata(req.value),
    .raddr(i[IW-1:0]), .rdata(rhs_q)
  );

  jscg_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_root_ram (
    .clk(clk), .we(root_we), .waddr(i[IW-1:0]), .wdata(sqrt_res.value[31:0]),
    .raddr(root_raddr), .rdata(root_q)
  );

  jscg_ram #(.WIDTH(64), .DEPTH(MAX_DIM)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(i[IW-1:0]), .wdata(x_wdata),
    .raddr(vaddr), .rdata(x_q)
  );

  jscg_ram #(.WIDTH(64), .DEPTH(MAX_DIM)) u_r_ram (
    .clk(clk), .we(r_we), .waddr(i[IW-1:0]), .wdata(r_wdata),
    .raddr(vaddr), .rdata(r_q)
  );

  jscg_ram #(.WIDTH(64), .DEPTH(MAX_DIM)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(i[IW-1:0]), .wdata(p_wdata),
    .raddr(vaddr), .rdata(p_q)
  );

  jscg_ram #(.WIDTH(64), .DEPTH(MAX_DIM)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(i[IW-1:0]), .wdata(acc),
    .raddr(vaddr), .rdata(q_q)
  );

  // Shared arithmetic units.
  jscg_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b), .res(mul_res)
  );

  jscg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d), .res(div_res)
  );

  jscg_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand({16'd0, a_q, 16'd0}),
    .res(sqrt_res)
  );

  // A result beat is never offered while input beats are taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("input ready while a result is offered");

  // Multiplier results arrive only while the sequencer waits for them.
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_res.done |-> (state == ST_MAC_WT || state == ST_UPD_W1 || state == ST_UPD_W2))
    else $error("multiplier result with no waiting step");

  // Divider results arrive only while the sequencer waits for them.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_SC_RWT || state == ST_SC_W1 || state == ST_SC_W2 ||
                      state == ST_QDIV_WT || state == ST_OUT_WT))
    else $error("divider result with no waiting step");

  // The final beat carries the last row in use.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last) |-> (rsp.index == 6'(n - CW'(1))))
    else $error("last beat on the wrong row");

endmodule
`default_nettype wire

/* rtl/core/jscg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jscg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/jscg_mul.sv */
// Iterative Q48.16 multiplier: four 32x32 partial products, saturated result.
`default_nettype none
module jscg_mul import jscg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output      unit_result_t res
);

  typedef enum logic [2:0] {
    MS_IDLE = 3'b001,
    MS_RUN  = 3'b010,
    MS_DONE = 3'b100
  } mul_state_t;

  mul_state_t   state;
  logic [2:0]   cnt;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [63:0]  pp;
  logic [1:0]   psh;
  logic [127:0] acc;
  logic [31:0]  ax;
  logic [31:0]  bx;
  logic [127:0] pp_shifted;

  // Operand halves for the current partial product.
  always_comb begin
    ax = (cnt == 3'd2 || cnt == 3'd3) ? ma[63:32] : ma[31:0];
    bx = (cnt == 3'd1 || cnt == 3'd3) ? mb[63:32] : mb[31:0];
    unique case (psh)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      default: pp_shifted = {pp, 64'd0};
    endcase
  end

  // Product in the first stage, accumulate in the second.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        MS_IDLE: begin
          if (start) begin
            ma    <= magnitude(a);
            mb    <= magnitude(b);
            neg   <= a[63] ^ b[63];
            acc   <= '0;
            cnt   <= '0;
            state <= MS_RUN;
          end
        end
        MS_RUN: begin
          if (cnt < 3'd4) begin
            pp  <= 64'(ax) * 64'(bx);
            psh <= (cnt == 3'd0) ? 2'd0 : ((cnt == 3'd3) ? 2'd2 : 2'd1);
          end
          if (cnt != 3'd0) begin
            acc <= acc + pp_shifted;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= MS_DONE;
          end
        end
        MS_DONE: state <= MS_IDLE;
        default: state <= MS_IDLE;
      endcase
    end
  end

  assign res.done  = (state == MS_DONE);
  assign res.value = from_mag(acc[79:16], neg, |acc[127:80]);

endmodule
`default_nettype wire

/* rtl/core/jscg_div.sv */
// Iterative Q48.16 divider: one quotient bit per cycle, 80 quotient bits in all.
`default_nettype none
module jscg_div import jscg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  num,
  input  wire logic [63:0]  den,
  output      unit_result_t res
);

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_RUN  = 3'b010,
    DS_DONE = 3'b100
  } div_state_t;

  div_state_t  state;
  logic [6:0]  cnt;
  logic [79:0] dvd;
  logic [63:0] dm;
  logic [63:0] rem;
  logic [63:0] q;
  logic        over;
  logic        neg;
  logic [63:0] rem_sh;
  logic        take;

  // Shift in the next dividend bit and test against the divisor.
  always_comb begin
    rem_sh = {rem[62:0], dvd[79]};
    take   = rem[63] || (rem_sh >= dm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DS_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        DS_IDLE: begin
          if (start) begin
            dvd   <= {magnitude(num), 16'd0};
            dm    <= magnitude(den);
            neg   <= num[63] ^ den[63];
            rem   <= '0;
            q     <= '0;
            over  <= 1'b0;
            cnt   <= 7'd80;
            state <= DS_RUN;
          end
        end
        DS_RUN: begin
          dvd  <= {dvd[78:0], 1'b0};
          over <= over | q[63];
          rem  <= take ? (rem_sh - dm) : rem_sh;
          q    <= {q[62:0], take};
          cnt  <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= DS_DONE;
          end
        end
        DS_DONE: state <= DS_IDLE;
        default: state <= DS_IDLE;
      endcase
    end
  end

  assign res.done  = (state == DS_DONE);
  assign res.value = from_mag(q, neg, over);

endmodule
`default_nettype wire

/* rtl/core/jscg_sqrt.sv */
// Iterative integer square root: two radicand bits per cycle across the 64-bit radicand.
`default_nettype none
module jscg_sqrt import jscg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  radicand,
  output      unit_result_t res
);

  typedef enum logic [2:0] {
    QS_IDLE = 3'b001,
    QS_RUN  = 3'b010,
    QS_DONE = 3'b100
  } sqrt_state_t;

  sqrt_state_t state;
  logic [5:0]  cnt;
  logic [63:0] v;
  logic [63:0] root;
  logic [63:0] bitr;
  logic [63:0] trial;

  assign trial = root + bitr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= QS_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        QS_IDLE: begin
          if (start) begin
            v     <= radicand;
            root  <= '0;
            bitr  <= 64'd1 << 62;
            cnt   <= 6'd32;
            state <= QS_RUN;
          end
        end
        QS_RUN: begin
          if (v >= trial) begin
            v    <= v - trial;
            root <= (root >> 1) + bitr;
          end else begin
            root <= root >> 1;
          end
          bitr <= bitr >> 2;
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= QS_DONE;
          end
        end
        QS_DONE: state <= QS_IDLE;
        default: state <= QS_IDLE;
      endcase
    end
  end

  assign res.done  = (state == QS_DONE);
  assign res.value = root;

endmodule
`default_nettype wire
